// File: hw/rtl/lcar_pkg.sv
// ----------------------------------------------------------------------------
// Load cell ADC reader package
// Shared types, codes and constants for the load cell converter reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

  // Conversion word and arithmetic widths.
  localparam int DATA_BITS   = 24;
  localparam int ACC_W       = 34;
  localparam int WEIGHT_W    = 45;
  localparam int COUNT_W     = 8;
  localparam int SCALE_W     = 32;
  localparam int Q_SHIFT     = 12;
  localparam int MUL_HALF_W  = ACC_W / 2;
  localparam int PROD_W      = MUL_HALF_W + SCALE_W;
  localparam int SUM_W       = ACC_W + SCALE_W;
  localparam int NUM_W       = SUM_W - 1 - Q_SHIFT;

  // Depth of the queue between the front and the sequencer.
  localparam int QUEUE_DEPTH = 2;

  // Default readings per weigh.
  localparam int SPW_DEFAULT = 5;

  // Reset values of the configuration registers.
  localparam logic [1:0]           GAIN_RESET   = 2'd0;
  localparam logic [SCALE_W-1:0]   SCALE_RESET  = 32'd164687;
  localparam logic [DATA_BITS-1:0] OFFSET_RESET = 24'd8021000;
  localparam logic [COUNT_W-1:0]   HALF_RESET   = 8'd1;

  // Offset binary conversion mask.
  localparam logic [DATA_BITS-1:0] SIGN_FLIP = 24'h800000;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WEIGH = 2'd1;
  localparam logic [1:0] CMD_TARE  = 2'd2;

  // Gain select codes.
  localparam logic [1:0] GAIN_128 = 2'd0;
  localparam logic [1:0] GAIN_32  = 2'd1;
  localparam logic [1:0] GAIN_64  = 2'd2;
  localparam logic [1:0] GAIN_BAD = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_ZERO  = 2'd2;
  localparam logic [1:0] REG_HALF  = 2'd3;

  // Kind of job an item starts, and the job in progress.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WEIGH,
    JOB_TARE
  } lcar_job_t;

  // One classified input word.
  typedef struct packed {
    lcar_job_t          kind;
    logic [COUNT_W-1:0] tare_n;
    logic               data;
  } lcar_item_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic               start;
    logic               weigh;
    logic [ACC_W-1:0]   acc;
    logic [SCALE_W-1:0] scale;
    logic [COUNT_W-1:0] divisor;
  } lcar_arith_req_t;

  // Response of the arithmetic unit.
  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] quot;
  } lcar_arith_res_t;

endpackage

// File: hw/rtl/lcar_front.sv
// ----------------------------------------------------------------------------
// Load cell ADC reader front
// Accepts input words, decodes the command and queues them for the sequencer.
// ----------------------------------------------------------------------------
module lcar_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_tare_count,
  input  logic                in_data_pin,
  output logic                item_valid,
  output lcar_pkg::lcar_item_t item,
  input  logic                item_pop
);
  import lcar_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lcar_item_t       queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  lcar_item_t       decoded;
  logic             push;

  // Classify the incoming word.
  always_comb begin
    decoded.data   = in_data_pin;
    decoded.tare_n = (in_tare_count == '0) ? COUNT_W'(1) : in_tare_count;
    case (in_command)
      CMD_WEIGH: decoded.kind = JOB_WEIGH;
      CMD_TARE:  decoded.kind = JOB_TARE;
      default:   decoded.kind = JOB_NONE;
    endcase
  end

  assign in_ready   = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count_r != '0);
  assign item       = queue_r[rd_ptr_r];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        queue_r[wr_ptr_r] <= decoded;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (item_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !item_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && item_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The sequencer only takes words that are present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid)
    else $error("word taken from an empty queue");

endmodule

// File: hw/rtl/lcar_arith.sv
// ----------------------------------------------------------------------------
// Load cell ADC reader arithmetic unit
// Scales a weigh sum by the Q20.12 factor and divides it by the reading count
// with one shared multiplier and a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module lcar_arith (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lcar_pkg::lcar_arith_req_t req,
  output lcar_pkg::lcar_arith_res_t res
);
  import lcar_pkg::*;

  localparam int DIV_CNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL_LO,
    AR_MUL_HI,
    AR_SUM,
    AR_DIV,
    AR_FIN
  } ar_state_t;

  ar_state_t              state_r;
  logic [ACC_W-1:0]       mag_r;
  logic [SCALE_W-1:0]     scale_r;
  logic [COUNT_W-1:0]     div_r;
  logic                   neg_r;
  logic [PROD_W-1:0]      pp_lo_r;
  logic [PROD_W-1:0]      pp_hi_r;
  logic [NUM_W-1:0]       num_r;
  logic [COUNT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   done_r;
  logic [WEIGHT_W-1:0]    quot_r;

  logic [ACC_W-1:0]       start_mag;
  logic [MUL_HALF_W-1:0]  mul_a;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_W:0]       trial;
  logic                   q_bit;
  logic [COUNT_W:0]       rem_sub;
  logic [NUM_W-1:0]       signed_q;

  // Magnitude of the accumulator; only a weigh sum is signed.
  assign start_mag = (req.weigh && req.acc[ACC_W-1]) ? (~req.acc + 1'b1) : req.acc;

  // One multiplier shared by the low and high halves of the magnitude.
  assign mul_a = (state_r == AR_MUL_LO) ? mag_r[MUL_HALF_W-1:0] : mag_r[ACC_W-1:MUL_HALF_W];
  assign prod  = PROD_W'(mul_a * scale_r);
  assign sum   = {pp_hi_r, {MUL_HALF_W{1'b0}}} + SUM_W'(pp_lo_r);

  // Restoring division step.
  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign q_bit   = (trial >= {1'b0, div_r});
  assign rem_sub = trial - {1'b0, div_r};

  // Quotient truncates toward zero: negate the magnitude quotient.
  assign signed_q = neg_r ? (~num_r + 1'b1) : num_r;

  // Unit sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        AR_IDLE: begin
          if (req.start) begin
            mag_r   <= start_mag;
            scale_r <= req.scale;
            div_r   <= req.divisor;
            neg_r   <= req.weigh && req.acc[ACC_W-1];
            rem_r   <= '0;
            cnt_r   <= DIV_CNT_W'(NUM_W - 1);
            num_r   <= NUM_W'(req.acc);
            state_r <= req.weigh ? AR_MUL_LO : AR_DIV;
          end
        end
        AR_MUL_LO: begin
          pp_lo_r <= prod;
          state_r <= AR_MUL_HI;
        end
        AR_MUL_HI: begin
          pp_hi_r <= prod;
          state_r <= AR_SUM;
        end
        AR_SUM: begin
          num_r   <= sum[SUM_W-2:Q_SHIFT];
          state_r <= AR_DIV;
        end
        AR_DIV: begin
          rem_r <= q_bit ? rem_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
          num_r <= {num_r[NUM_W-2:0], q_bit};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= AR_FIN;
          end
        end
        AR_FIN: begin
          quot_r  <= signed_q[WEIGHT_W-1:0];
          done_r  <= 1'b1;
          state_r <= AR_IDLE;
        end
        default: begin
          state_r <= AR_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

  // A new job is only started while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == AR_IDLE)
    else $error("arithmetic start while busy");

endmodule

// File: hw/rtl/lcar_seq.sv
// ----------------------------------------------------------------------------
// Load cell ADC reader sequencer
// Runs the serial clock timing, shifts in conversions, accumulates readings,
// holds the configuration registers and drives the result register.
// ----------------------------------------------------------------------------
module lcar_seq #(
  parameter int SAMPLES_PER_WEIGHT = lcar_pkg::SPW_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               item_valid,
  input  lcar_pkg::lcar_item_t                item,
  output logic                               item_pop,
  output lcar_pkg::lcar_arith_req_t           req,
  input  lcar_pkg::lcar_arith_res_t           res,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_clock_pin,
  output logic                               out_busy_res,
  output logic                               out_weight_valid,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] out_weight,
  output logic                               out_tare_valid,
  output logic [lcar_pkg::DATA_BITS-1:0]     out_offset_value
);
  import lcar_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    EX_RUN,
    EX_LAUNCH,
    EX_WAIT
  } exec_t;

  function automatic logic [4:0] gain_pulses(input logic [1:0] g);
    case (g)
      GAIN_32: gain_pulses = 5'd2;
      GAIN_64: gain_pulses = 5'd3;
      default: gain_pulses = 5'd1;
    endcase
  endfunction

  phase_t                  phase_r, phase_nxt;
  lcar_job_t               job_r, job_nxt;
  exec_t                   ex_r, ex_nxt;
  logic                    fin_weigh_r, fin_weigh_nxt;
  logic [4:0]              pulse_r, pulse_nxt;
  logic [COUNT_W-1:0]      timer_r, timer_nxt;
  logic [DATA_BITS-1:0]    shift_r, shift_nxt;
  logic [COUNT_W-1:0]      left_r, left_nxt;
  logic [COUNT_W-1:0]      total_r, total_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [DATA_BITS-1:0]    offset_r, offset_nxt;
  logic [1:0]              gain_r, gain_nxt;
  logic [SCALE_W-1:0]      scale_r, scale_nxt;
  logic [COUNT_W-1:0]      half_r, half_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_clk_r, out_clk_nxt;
  logic                    out_busy_r, out_busy_nxt;
  logic                    out_wv_r, out_wv_nxt;
  logic [WEIGHT_W-1:0]     out_weight_r, out_weight_nxt;
  logic                    out_tv_r, out_tv_nxt;
  logic [DATA_BITS-1:0]    out_offset_r, out_offset_nxt;

  logic                    out_free;
  logic                    step;
  logic [COUNT_W-1:0]      hp;
  logic [COUNT_W-1:0]      timer_inc;
  logic [4:0]              pulse_inc;
  logic [4:0]              end_count;
  logic [DATA_BITS-1:0]    shift_new;
  logic [DATA_BITS-1:0]    raw;
  logic [DATA_BITS:0]      diff;
  logic [ACC_W-1:0]        acc_sum;
  logic [COUNT_W-1:0]      left_dec;
  logic                    job_end;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = (ex_r == EX_RUN) && item_valid && out_free;
  assign item_pop  = step;

  // Datapath for the end of a low half period.
  always_comb begin
    hp        = (half_r == '0) ? COUNT_W'(1) : half_r;
    timer_inc = timer_r + 1'b1;
    pulse_inc = pulse_r + 1'b1;
    end_count = 5'(DATA_BITS) + gain_pulses(gain_r);
    shift_new = (pulse_inc <= 5'(DATA_BITS)) ? {shift_r[DATA_BITS-2:0], item.data} : shift_r;
    raw       = shift_new ^ SIGN_FLIP;
    diff      = {1'b0, raw} - {1'b0, offset_r};
    acc_sum   = (job_r == JOB_WEIGH) ? acc_r + {{(ACC_W-DATA_BITS-1){diff[DATA_BITS]}}, diff}
                                     : acc_r + ACC_W'(raw);
    left_dec  = (left_r == '0) ? '0 : left_r - 1'b1;
  end

  // Next state of the sequencer, the result register and the configuration.
  always_comb begin
    phase_nxt      = phase_r;
    job_nxt        = job_r;
    ex_nxt         = ex_r;
    fin_weigh_nxt  = fin_weigh_r;
    pulse_nxt      = pulse_r;
    timer_nxt      = timer_r;
    shift_nxt      = shift_r;
    left_nxt       = left_r;
    total_nxt      = total_r;
    acc_nxt        = acc_r;
    offset_nxt     = offset_r;
    gain_nxt       = gain_r;
    scale_nxt      = scale_r;
    half_nxt       = half_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_clk_nxt    = out_clk_r;
    out_busy_nxt   = out_busy_r;
    out_wv_nxt     = out_wv_r;
    out_weight_nxt = out_weight_r;
    out_tv_nxt     = out_tv_r;
    out_offset_nxt = out_offset_r;
    job_end        = 1'b0;

    req.start   = (ex_r == EX_LAUNCH);
    req.weigh   = fin_weigh_r;
    req.acc     = acc_r;
    req.scale   = scale_r;
    req.divisor = total_r;

    case (ex_r)
      EX_RUN: begin
        if (step) begin
          case (phase_r)
            PH_IDLE: begin
              if (item.kind != JOB_NONE) begin
                job_nxt   = item.kind;
                total_nxt = (item.kind == JOB_WEIGH) ? COUNT_W'(SAMPLES_PER_WEIGHT) : item.tare_n;
                left_nxt  = total_nxt;
                acc_nxt   = '0;
                phase_nxt = PH_WAIT;
              end
            end
            PH_WAIT: begin
              if (!item.data) begin
                phase_nxt = PH_HIGH;
                timer_nxt = '0;
                pulse_nxt = '0;
              end
            end
            PH_HIGH: begin
              timer_nxt = timer_inc;
              if (timer_inc >= hp) begin
                timer_nxt = '0;
                phase_nxt = PH_LOW;
              end
            end
            PH_LOW: begin
              timer_nxt = timer_inc;
              if (timer_inc >= hp) begin
                timer_nxt = '0;
                pulse_nxt = pulse_inc;
                shift_nxt = shift_new;
                if (pulse_inc < end_count) begin
                  phase_nxt = PH_HIGH;
                end else begin
                  acc_nxt  = acc_sum;
                  left_nxt = left_dec;
                  if (left_dec == '0) begin
                    fin_weigh_nxt = (job_r == JOB_WEIGH);
                    phase_nxt     = PH_IDLE;
                    job_nxt       = JOB_NONE;
                    ex_nxt        = EX_LAUNCH;
                    job_end       = 1'b1;
                  end else begin
                    phase_nxt = PH_WAIT;
                  end
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase

          // An ordinary tick reports at once; a finished job waits for the math.
          if (!job_end) begin
            out_valid_nxt  = 1'b1;
            out_clk_nxt    = (phase_nxt == PH_HIGH);
            out_busy_nxt   = (phase_nxt != PH_IDLE);
            out_wv_nxt     = 1'b0;
            out_weight_nxt = '0;
            out_tv_nxt     = 1'b0;
            out_offset_nxt = offset_nxt;
          end
        end
      end
      EX_LAUNCH: begin
        ex_nxt = EX_WAIT;
      end
      EX_WAIT: begin
        if (res.done) begin
          ex_nxt        = EX_RUN;
          out_valid_nxt = 1'b1;
          out_clk_nxt   = 1'b0;
          out_busy_nxt  = 1'b0;
          if (fin_weigh_r) begin
            out_wv_nxt     = 1'b1;
            out_weight_nxt = res.quot;
            out_tv_nxt     = 1'b0;
          end else begin
            offset_nxt     = res.quot[DATA_BITS-1:0];
            out_wv_nxt     = 1'b0;
            out_weight_nxt = '0;
            out_tv_nxt     = 1'b1;
          end
          out_offset_nxt = offset_nxt;
        end
      end
      default: begin
        ex_nxt = EX_RUN;
      end
    endcase

    // Register writes take effect at once; an invalid gain code is ignored.
    if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN: begin
          if (cfg_data[1:0] != GAIN_BAD) begin
            gain_nxt = cfg_data[1:0];
          end
        end
        REG_SCALE: scale_nxt  = cfg_data;
        REG_ZERO:  offset_nxt = cfg_data[DATA_BITS-1:0];
        REG_HALF:  half_nxt   = cfg_data[COUNT_W-1:0];
        default: begin
          half_nxt = half_r;
        end
      endcase
    end
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      job_r       <= JOB_NONE;
      ex_r        <= EX_RUN;
      fin_weigh_r <= 1'b0;
      pulse_r     <= '0;
      timer_r     <= '0;
      shift_r     <= '0;
      left_r      <= '0;
      total_r     <= '0;
      acc_r       <= '0;
      offset_r    <= OFFSET_RESET;
      gain_r      <= GAIN_RESET;
      scale_r     <= SCALE_RESET;
      half_r      <= HALF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      job_r        <= job_nxt;
      ex_r         <= ex_nxt;
      fin_weigh_r  <= fin_weigh_nxt;
      pulse_r      <= pulse_nxt;
      timer_r      <= timer_nxt;
      shift_r      <= shift_nxt;
      left_r       <= left_nxt;
      total_r      <= total_nxt;
      acc_r        <= acc_nxt;
      offset_r     <= offset_nxt;
      gain_r       <= gain_nxt;
      scale_r      <= scale_nxt;
      half_r       <= half_nxt;
      out_valid_r  <= out_valid_nxt;
      out_clk_r    <= out_clk_nxt;
      out_busy_r   <= out_busy_nxt;
      out_wv_r     <= out_wv_nxt;
      out_weight_r <= out_weight_nxt;
      out_tv_r     <= out_tv_nxt;
      out_offset_r <= out_offset_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clock_pin    = out_clk_r;
  assign out_busy_res     = out_busy_r;
  assign out_weight_valid = out_wv_r;
  assign out_weight       = $signed(out_weight_r);
  assign out_tare_valid   = out_tv_r;
  assign out_offset_value = out_offset_r;

  // The arithmetic unit only answers a job that was launched.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> ex_r == EX_WAIT)
    else $error("arithmetic result with no job waiting");

  // A job's final word is reported with the converter idle.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_wv_r || out_tv_r) |-> !out_busy_r && !out_clk_r && !(out_wv_r && out_tv_r))
    else $error("job end reported while busy");

  // The arithmetic launch follows the final step of a job.
  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ex_r == EX_LAUNCH |-> phase_r == PH_IDLE && job_r == JOB_NONE)
    else $error("arithmetic launched with a job still running");

endmodule

// File: hw/rtl/load_cell_adc_reader_core.sv
// ----------------------------------------------------------------------------
// Load cell ADC reader core
// Bit-banged reader for a 24-bit load cell converter, advanced one tick per
// input word, with weigh averaging, scaling and tare.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Ports                                         | Handshake
//   --------+-----+-----------------------------------------------+-----------
//   in      | in  | in_command, in_tare_count, in_data_pin        | valid/ready
//   out     | out | out_clock_pin, out_busy_res, out_weight_valid,| valid/ready
//           |     | out_weight, out_tare_valid, out_offset_value  |
//   cfg     | in  | cfg_index, cfg_data                           | valid/ready
//
// Every input word yields exactly one output word. Ordinary ticks stream at one
// word per cycle while the output is taken. The tick that ends a job runs the
// arithmetic unit first: the two multiplier passes for a weigh, then the
// one-bit-per-cycle divider over the 53-bit scaled sum.
// Reset is synchronous; configuration returns to its defaults. The cfg port
// always accepts. A stalled output fills the two-word queue, then in_ready drops.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_core #(
  parameter int SAMPLES_PER_WEIGHT = lcar_pkg::SPW_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_command,
  input  logic [7:0]                         in_tare_count,
  input  logic                               in_data_pin,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_clock_pin,
  output logic                               out_busy_res,
  output logic                               out_weight_valid,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] out_weight,
  output logic                               out_tare_valid,
  output logic [lcar_pkg::DATA_BITS-1:0]     out_offset_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import lcar_pkg::*;

  lcar_item_t      item;
  logic            item_valid;
  logic            item_pop;
  lcar_arith_req_t req;
  lcar_arith_res_t res;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Front: decode and queue input words.
  lcar_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_tare_count(in_tare_count),
    .in_data_pin  (in_data_pin),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  // Back: timing sequencer and result register.
  lcar_seq #(
    .SAMPLES_PER_WEIGHT(SAMPLES_PER_WEIGHT)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .req             (req),
    .res             (res),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_clock_pin   (out_clock_pin),
    .out_busy_res    (out_busy_res),
    .out_weight_valid(out_weight_valid),
    .out_weight      (out_weight),
    .out_tare_valid  (out_tare_valid),
    .out_offset_value(out_offset_value)
  );

  // Multiply and divide unit for job results.
  lcar_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .res  (res)
  );

endmodule
